// ===== rtl/core/pip_pkg.sv =====
// Point-in-polygon test: shared widths, action codes and pipeline structs.
// Used by the test unit and the edge pipeline; depends on nothing.
package pip_pkg;

    // Coordinate and ray widths
    localparam int COORD_W = 16;
    localparam int RAY_W   = 16;

    // Vertex store geometry
    localparam int MAX_VERTICES = 64;
    localparam int MIN_VERTICES = 3;
    localparam int VADDR_W      = $clog2(MAX_VERTICES);
    localparam int VCNT_W       = $clog2(MAX_VERTICES + 1);
    localparam int VERT_W       = 2 * COORD_W;

    // Exact orientation arithmetic
    localparam int DIFF_W = ((COORD_W > RAY_W) ? COORD_W : RAY_W) + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int ORI_W  = PROD_W + 1;

    // Ray end after reset
    localparam logic signed [RAY_W-1:0] RAY_RESET = RAY_W'(9999);

    // Item actions
    typedef enum logic [1:0] {
        ACT_START  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_QUERY  = 2'd2
    } action_t;

    // One closed edge, a -> b, vertex word is {y, x}
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [VERT_W-1:0] a;
        logic [VERT_W-1:0] b;
    } edge_t;

    // Outcome of one edge against the ray
    typedef struct packed {
        logic valid;
        logic last;
        logic meet;       // ray segment touches the edge
        logic collinear;  // point collinear with the edge
        logic on_edge;    // point within the edge's bounding box
    } edge_res_t;

endpackage

// ===== rtl/core/point_in_polygon_test_unit.sv =====
// Point-in-polygon test unit: control, vertex store and edge pipeline.
// Depends on pip_pkg, pip_vertex_ram and pip_edge_test.
//
// Start and append words give no result. A query against fewer than three
// vertices answers in the cycle after it is taken. Otherwise the unit reads
// the n stored vertices, one per cycle through the single read port of the
// vertex memory, and tests one closed edge per cycle; a query holds busy
// until its result strobes on done, and a point found collinear with a crossed
// edge ends the query early. Each result is on the ports for the one cycle
// that done is high and must be taken then. Write ray_end_x through cfg_we
// and cfg_wdata only while busy is low and no query is pending.
module point_in_polygon_test_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         action,
    input  logic signed [pip_pkg::COORD_W-1:0] coord_x,
    input  logic signed [pip_pkg::COORD_W-1:0] coord_y,
    input  logic                               cfg_we,
    input  logic signed [pip_pkg::RAY_W-1:0]   cfg_wdata,
    output logic                               done,
    output logic                               inside_res,
    output logic                               status,
    output logic                               overflowed
);
    import pip_pkg::*;

    typedef enum logic {S_IDLE, S_RUN} state_t;

    state_t                   state_reg;
    logic [VCNT_W-1:0]        count_reg;
    logic [VCNT_W-1:0]        issue_cnt_reg;
    logic                     ovf_reg;
    logic                     issuing_reg;
    logic                     rd_pend_reg;
    logic                     rd_first_reg;
    logic                     rd_last_reg;
    logic                     edge_vld_reg;
    logic                     edge_last_reg;
    logic                     parity_reg;
    logic signed [RAY_W-1:0]  ray_x_reg;
    logic                     done_reg, inside_reg, status_reg, ovf_out_reg;

    logic signed [COORD_W-1:0] px_reg, py_reg;
    logic [VERT_W-1:0]         prev_reg, edge_a_reg, edge_b_reg;

    logic               accept;
    logic               has_room;
    logic               wr_en;
    logic [VADDR_W-1:0] wr_addr;
    logic [VADDR_W-1:0] rd_addr;
    logic [VERT_W-1:0]  rd_data;
    edge_t              edge_word;
    edge_res_t          res;
    logic               decided, finish, final_inside;

    // Handshake and store writes
    assign busy     = (state_reg != S_IDLE);
    assign accept   = start && !busy;
    assign has_room = (count_reg < VCNT_W'(MAX_VERTICES));
    assign wr_en    = accept && ((action == ACT_START) || ((action == ACT_APPEND) && has_room));
    assign wr_addr  = (action == ACT_START) ? '0 : count_reg[VADDR_W-1:0];

    // Read sweep: vertices 0 .. n-1, then vertex 0 again to close the polygon
    assign rd_addr = (issue_cnt_reg == count_reg) ? '0 : issue_cnt_reg[VADDR_W-1:0];

    pip_vertex_ram #(
        .DEPTH (MAX_VERTICES),
        .WIDTH (VERT_W)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata ({coord_y, coord_x}),
        .re    (issuing_reg),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign edge_word.valid = edge_vld_reg;
    assign edge_word.last  = edge_last_reg;
    assign edge_word.a     = edge_a_reg;
    assign edge_word.b     = edge_b_reg;

    pip_edge_test u_edge (
        .clk     (clk),
        .rst_n   (rst_n),
        .edge_in (edge_word),
        .ray_x   (ray_x_reg),
        .px      (px_reg),
        .py      (py_reg),
        .flush   (finish),
        .res     (res)
    );

    // A collinear crossing decides at once; otherwise the last edge ends the query
    assign decided      = res.meet && res.collinear;
    assign finish       = res.valid && (decided || res.last);
    assign final_inside = decided ? res.on_edge : (parity_reg ^ res.meet);

    // Control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            issue_cnt_reg <= '0;
            ovf_reg       <= 1'b0;
            issuing_reg   <= 1'b0;
            rd_pend_reg   <= 1'b0;
            rd_first_reg  <= 1'b0;
            rd_last_reg   <= 1'b0;
            edge_vld_reg  <= 1'b0;
            edge_last_reg <= 1'b0;
            parity_reg    <= 1'b0;
            ray_x_reg     <= RAY_RESET;
            done_reg      <= 1'b0;
            inside_reg    <= 1'b0;
            status_reg    <= 1'b0;
            ovf_out_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                ray_x_reg <= cfg_wdata;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        case (action)
                            ACT_START:
                            begin
                                count_reg <= VCNT_W'(1);
                                ovf_reg   <= 1'b0;
                            end
                            ACT_APPEND:
                            begin
                                if (has_room)
                                begin
                                    count_reg <= count_reg + 1'b1;
                                end
                                else
                                begin
                                    ovf_reg <= 1'b1;
                                end
                            end
                            ACT_QUERY:
                            begin
                                if (count_reg < VCNT_W'(MIN_VERTICES))
                                begin
                                    done_reg    <= 1'b1;
                                    inside_reg  <= 1'b0;
                                    status_reg  <= 1'b1;
                                    ovf_out_reg <= ovf_reg;
                                end
                                else
                                begin
                                    state_reg     <= S_RUN;
                                    issuing_reg   <= 1'b1;
                                    issue_cnt_reg <= '0;
                                    parity_reg    <= 1'b0;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_RUN:
                begin
                    // read issue
                    if (issuing_reg)
                    begin
                        issue_cnt_reg <= issue_cnt_reg + 1'b1;
                        if (issue_cnt_reg == count_reg)
                        begin
                            issuing_reg <= 1'b0;
                        end
                    end
                    rd_pend_reg  <= issuing_reg;
                    rd_first_reg <= (issue_cnt_reg == '0);
                    rd_last_reg  <= (issue_cnt_reg == count_reg);

                    // edge formation: first word only primes the previous vertex
                    edge_vld_reg  <= rd_pend_reg && !rd_first_reg;
                    edge_last_reg <= rd_last_reg;

                    // crossing parity
                    if (res.valid && res.meet)
                    begin
                        parity_reg <= !parity_reg;
                    end

                    // answer and flush
                    if (finish)
                    begin
                        state_reg    <= S_IDLE;
                        issuing_reg  <= 1'b0;
                        rd_pend_reg  <= 1'b0;
                        edge_vld_reg <= 1'b0;
                        done_reg     <= 1'b1;
                        inside_reg   <= final_inside;
                        status_reg   <= 1'b0;
                        ovf_out_reg  <= ovf_reg;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Query point and edge operands
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg <= coord_x;
            py_reg <= coord_y;
        end
        if (rd_pend_reg)
        begin
            prev_reg   <= rd_data;
            edge_a_reg <= prev_reg;
            edge_b_reg <= rd_data;
        end
    end

    assign done       = done_reg;
    assign inside_res = inside_reg;
    assign status     = status_reg;
    assign overflowed = ovf_out_reg;

    // Checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= VCNT_W'(MAX_VERTICES))
        else $error("vertex count beyond store depth");

    a_res_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (state_reg == S_RUN))
        else $error("edge outcome outside a query");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == S_IDLE))
        else $error("result strobed while a query runs");

    a_small_query: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (action == ACT_QUERY) && (count_reg < VCNT_W'(MIN_VERTICES)))
        |=> (done && status && !inside_res))
        else $error("small polygon query not answered at once");

    a_no_read_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !issuing_reg)
        else $error("vertex read issued while idle");

endmodule

// ===== rtl/core/pip_vertex_ram.sv =====
// Vertex store: single-port-write, single-port-read synchronous RAM.
// Registered read data. No package dependency.
module pip_vertex_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/core/pip_edge_test.sv =====
// Edge-versus-ray test pipeline: differences, products, orientation signs.
// Three register stages; depends on pip_pkg.
module pip_edge_test (
    input  logic                               clk,
    input  logic                               rst_n,
    input  pip_pkg::edge_t                     edge_in,
    input  logic signed [pip_pkg::RAY_W-1:0]   ray_x,
    input  logic signed [pip_pkg::COORD_W-1:0] px,
    input  logic signed [pip_pkg::COORD_W-1:0] py,
    input  logic                               flush,
    output pip_pkg::edge_res_t                 res
);
    import pip_pkg::*;

    function automatic logic signed [DIFF_W-1:0] ext_c(input logic signed [COORD_W-1:0] v);
        return DIFF_W'(v);
    endfunction

    function automatic logic signed [DIFF_W-1:0] ext_r(input logic signed [RAY_W-1:0] v);
        return DIFF_W'(v);
    endfunction

    // Unpacked operands, all widened to DIFF_W
    logic signed [DIFF_W-1:0] ax, ay, bx, by, pxe, pye, exe;
    logic signed [DIFF_W-1:0] lo_x, hi_x, lo_y, hi_y, lo_r, hi_r;

    assign ax  = ext_c(edge_in.a[COORD_W-1:0]);
    assign ay  = ext_c(edge_in.a[VERT_W-1:COORD_W]);
    assign bx  = ext_c(edge_in.b[COORD_W-1:0]);
    assign by  = ext_c(edge_in.b[VERT_W-1:COORD_W]);
    assign pxe = ext_c(px);
    assign pye = ext_c(py);
    assign exe = ext_r(ray_x);

    assign lo_x = (ax < bx) ? ax : bx;
    assign hi_x = (ax < bx) ? bx : ax;
    assign lo_y = (ay < by) ? ay : by;
    assign hi_y = (ay < by) ? by : ay;
    assign lo_r = (pxe < exe) ? pxe : exe;
    assign hi_r = (pxe < exe) ? exe : pxe;

    // Stage 1 flags: ray endpoints against the edge box, edge ends against the ray
    logic y_in, box_p, box_e;
    logic z3, n3, z4, n4, d34_ne, c34;

    assign y_in  = (pye >= lo_y) && (pye <= hi_y);
    assign box_p = (pxe >= lo_x) && (pxe <= hi_x) && y_in;
    assign box_e = (exe >= lo_x) && (exe <= hi_x) && y_in;

    // Orientation of a and b seen from the ray: sign of -(ex-px)(y-py)
    assign z3 = (exe == pxe) || (ay == pye);
    assign n3 = ((exe > pxe) && (ay > pye)) || ((exe < pxe) && (ay < pye));
    assign z4 = (exe == pxe) || (by == pye);
    assign n4 = ((exe > pxe) && (by > pye)) || ((exe < pxe) && (by < pye));
    assign d34_ne = (z3 != z4) || (!z3 && (n3 != n4));
    assign c34 = (z3 && (ay == pye) && (ax >= lo_r) && (ax <= hi_r)) ||
                 (z4 && (by == pye) && (bx >= lo_r) && (bx <= hi_r));

    // Stage 1 registers
    logic s1_vld_reg, s1_last_reg;
    logic signed [DIFF_W-1:0] d_a_reg, d_pb_reg, d_eb_reg, d_ba_reg, d_yb_reg;
    logic s1_box_p_reg, s1_box_e_reg, s1_d34_reg, s1_c34_reg;

    // Stage 2 registers
    logic s2_vld_reg, s2_last_reg;
    logic signed [PROD_W-1:0] p1_reg, p2_reg, p3_reg;
    logic s2_box_p_reg, s2_box_e_reg, s2_d34_reg, s2_c34_reg;

    // Stage 3 registers
    logic res_vld_reg, res_last_reg;
    logic meet_reg, coll_reg, on_edge_reg;

    // Control: valid and last travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg   <= 1'b0;
            s1_last_reg  <= 1'b0;
            s2_vld_reg   <= 1'b0;
            s2_last_reg  <= 1'b0;
            res_vld_reg  <= 1'b0;
            res_last_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg   <= edge_in.valid && !flush;
            s1_last_reg  <= edge_in.last;
            s2_vld_reg   <= s1_vld_reg && !flush;
            s2_last_reg  <= s1_last_reg;
            res_vld_reg  <= s2_vld_reg && !flush;
            res_last_reg <= s2_last_reg;
        end
    end

    // Stage 3 combine: d1 = A*(px-bx) - B, d2 = A*(ex-bx) - B
    logic signed [ORI_W-1:0] v1, v2;
    logic z1, z2, d12_ne, meet_next;

    assign v1 = ORI_W'(p1_reg) - ORI_W'(p3_reg);
    assign v2 = ORI_W'(p2_reg) - ORI_W'(p3_reg);
    assign z1 = (v1 == '0);
    assign z2 = (v2 == '0);
    assign d12_ne = (z1 != z2) || (!z1 && (v1[ORI_W-1] != v2[ORI_W-1]));
    assign meet_next = (d12_ne && s2_d34_reg) || (z1 && s2_box_p_reg) ||
                       (z2 && s2_box_e_reg) || s2_c34_reg;

    // Datapath
    always_ff @(posedge clk)
    begin
        // differences and flags
        d_a_reg      <= by - ay;
        d_pb_reg     <= pxe - bx;
        d_eb_reg     <= exe - bx;
        d_ba_reg     <= bx - ax;
        d_yb_reg     <= pye - by;
        s1_box_p_reg <= box_p;
        s1_box_e_reg <= box_e;
        s1_d34_reg   <= d34_ne;
        s1_c34_reg   <= c34;
        // products
        p1_reg       <= PROD_W'(d_a_reg) * PROD_W'(d_pb_reg);
        p2_reg       <= PROD_W'(d_a_reg) * PROD_W'(d_eb_reg);
        p3_reg       <= PROD_W'(d_ba_reg) * PROD_W'(d_yb_reg);
        s2_box_p_reg <= s1_box_p_reg;
        s2_box_e_reg <= s1_box_e_reg;
        s2_d34_reg   <= s1_d34_reg;
        s2_c34_reg   <= s1_c34_reg;
        // outcome
        meet_reg     <= meet_next;
        coll_reg     <= z1;
        on_edge_reg  <= s2_box_p_reg;
    end

    assign res.valid     = res_vld_reg;
    assign res.last      = res_last_reg;
    assign res.meet      = meet_reg;
    assign res.collinear = coll_reg;
    assign res.on_edge   = on_edge_reg;

endmodule
